FILE: sv/sld_pkg.sv
// Shared types and constants of the sync and length framed byte deframer.
package sld_pkg;

    localparam int BYTE_W   = 8;
    localparam int ROLE_W   = 3;
    localparam int OFFSET_W = 17;
    localparam int LENGTH_W = 16;
    localparam int CFG_INDEX_W = 8;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [BYTE_W-1:0] FIRST_SYNC_RESET  = 8'hFA;
    localparam logic [BYTE_W-1:0] SECOND_SYNC_RESET = 8'h0A;

    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_SYNC  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECOND_SYNC = 8'd1;

    localparam logic [ROLE_W-1:0] ROLE_SYNC1   = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_SYNC2   = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_FCODE   = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_ID      = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_LENGTH  = 3'd4;
    localparam logic [ROLE_W-1:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [ROLE_W-1:0] ROLE_TRAILER = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0]   frame_byte;
        logic [ROLE_W-1:0]   byte_role;
        logic [OFFSET_W-1:0] byte_offset;
        logic                frame_last;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_queue_status;

endpackage

FILE: sv/sld_front.sv
// Front end: accepts received bytes, tracks the frame layout and tags frame bytes.
module sld_front
    import sld_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rx_valid,
    output logic                o_rx_ready,
    input  logic [BYTE_W-1:0]   i_rx_byte,
    input  logic [BYTE_W-1:0]   i_first_sync,
    input  logic [BYTE_W-1:0]   i_second_sync,
    input  t_queue_status       i_status,
    output logic                o_push,
    output t_item               o_item
);

    typedef enum logic [2:0] {
        PH_SYNC1, PH_SYNC2, PH_FCODE, PH_ID, PH_LENGTH, PH_PAYLOAD, PH_TRAIL1, PH_TRAIL2
    } t_phase;

    t_phase              r_phase, n_phase;
    logic                r_pair, n_pair;
    logic [BYTE_W-1:0]   r_len_low, n_len_low;
    logic [LENGTH_W-1:0] r_remaining, n_remaining;
    logic [OFFSET_W-1:0] r_offset, n_offset;

    logic                accept;
    logic                emit;
    logic [ROLE_W-1:0]   role;
    logic                last;
    logic [OFFSET_W-1:0] cur_offset;
    logic [LENGTH_W-1:0] length_full;

    assign o_rx_ready  = !i_status.full;
    assign accept      = i_rx_valid && o_rx_ready;
    assign length_full = {i_rx_byte, r_len_low};

    always_comb begin
        n_phase     = r_phase;
        n_pair      = r_pair;
        n_len_low   = r_len_low;
        n_remaining = r_remaining;
        emit        = 1'b1;
        role        = ROLE_TRAILER;
        last        = 1'b0;
        cur_offset  = r_offset;
        case (r_phase)
            PH_SYNC1: begin
                role       = ROLE_SYNC1;
                cur_offset = '0;
                emit       = (i_rx_byte == i_first_sync);
                if (emit) begin
                    n_pair  = 1'b0;
                    n_phase = PH_SYNC2;
                end
            end
            PH_SYNC2: begin
                role = ROLE_SYNC2;
                emit = (i_rx_byte == i_second_sync);
                if (emit) begin
                    n_phase = PH_FCODE;
                end
            end
            PH_FCODE: begin
                role    = ROLE_FCODE;
                n_pair  = 1'b0;
                n_phase = PH_ID;
            end
            PH_ID: begin
                role   = ROLE_ID;
                n_pair = !r_pair;
                if (r_pair) begin
                    n_phase = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                role   = ROLE_LENGTH;
                n_pair = !r_pair;
                if (r_pair) begin
                    n_remaining = length_full;
                    n_phase     = (length_full == '0) ? PH_TRAIL1 : PH_PAYLOAD;
                end else begin
                    n_len_low = i_rx_byte;
                end
            end
            PH_PAYLOAD: begin
                role = ROLE_PAYLOAD;
                if (r_remaining <= LENGTH_W'(1)) begin
                    n_remaining = '0;
                    n_phase     = PH_TRAIL1;
                end else begin
                    n_remaining = r_remaining - LENGTH_W'(1);
                end
            end
            PH_TRAIL1: begin
                n_phase = PH_TRAIL2;
            end
            PH_TRAIL2: begin
                last    = 1'b1;
                n_pair  = 1'b0;
                n_phase = PH_SYNC1;
            end
            default: begin
                emit    = 1'b0;
                n_phase = PH_SYNC1;
            end
        endcase
        if (!emit) begin
            n_offset = r_offset;
        end else if (last) begin
            n_offset = '0;
        end else begin
            n_offset = cur_offset + OFFSET_W'(1);
        end
    end

    assign o_push             = accept && emit;
    assign o_item.frame_byte  = i_rx_byte;
    assign o_item.byte_role   = role;
    assign o_item.byte_offset = cur_offset;
    assign o_item.frame_last  = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SYNC1;
            r_pair      <= 1'b0;
            r_len_low   <= '0;
            r_remaining <= '0;
            r_offset    <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_pair      <= n_pair;
            r_len_low   <= n_len_low;
            r_remaining <= n_remaining;
            r_offset    <= n_offset;
        end
    end

endmodule

FILE: sv/sld_queue.sv
// Short first-in first-out queue of tagged frame bytes between front and back ends.
module sld_queue
    import sld_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  t_item         i_item,
    input  logic          i_pop,
    output t_item         o_item,
    output t_queue_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_item         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

FILE: sv/sld_back.sv
// Back end: takes tagged bytes from the queue into the output register.
module sld_back
    import sld_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_queue_status i_status,
    input  t_item         i_item,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_item         o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_pop       = !i_status.empty && (!r_valid || i_out_ready);
    assign o_out_valid = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: sv/sync_length_frame_deframer_unit.sv
// Top level of the sync and length framed byte deframer.
//
//  Channel  Direction  Handshake                   Payload
//  rx       in         i_rx_valid / o_rx_ready     i_rx_byte
//  cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//  out      out        o_out_valid / i_out_ready   o_frame_byte, o_byte_role,
//                                                  o_byte_offset, o_frame_last
//
// One byte is accepted per cycle while the queue is not full; the parser tags it in
// the same cycle and writes it into the queue at the accepting edge, and it moves
// to the output register once that register is empty or being taken. Dropped bytes
// yield no output. Reset is synchronous; the sync values return to 0xFA and 0x0A. A
// stalled output fills the queue, and input is held off only once the queue is full.
module sync_length_frame_deframer_unit
    import sld_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_rx_valid,
    output logic                   o_rx_ready,
    input  logic [BYTE_W-1:0]      i_rx_byte,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [BYTE_W-1:0]      i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [BYTE_W-1:0]      o_frame_byte,
    output logic [ROLE_W-1:0]      o_byte_role,
    output logic [OFFSET_W-1:0]    o_byte_offset,
    output logic                   o_frame_last
);

    logic [BYTE_W-1:0] r_first_sync, r_second_sync;
    logic              cfg_write;
    t_queue_status     status;
    logic              push, pop;
    t_item             push_item, queue_item, out_item;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_sync  <= FIRST_SYNC_RESET;
            r_second_sync <= SECOND_SYNC_RESET;
        end else if (cfg_write) begin
            if (i_cfg_index == CFG_FIRST_SYNC) begin
                r_first_sync <= i_cfg_data;
            end else if (i_cfg_index == CFG_SECOND_SYNC) begin
                r_second_sync <= i_cfg_data;
            end
        end
    end

    sld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rx_valid    (i_rx_valid),
        .o_rx_ready    (o_rx_ready),
        .i_rx_byte     (i_rx_byte),
        .i_first_sync  (r_first_sync),
        .i_second_sync (r_second_sync),
        .i_status      (status),
        .o_push        (push),
        .o_item        (push_item)
    );

    sld_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (queue_item),
        .o_status (status)
    );

    sld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (status),
        .i_item      (queue_item),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_item      (out_item)
    );

    assign o_frame_byte  = out_item.frame_byte;
    assign o_byte_role   = out_item.byte_role;
    assign o_byte_offset = out_item.byte_offset;
    assign o_frame_last  = out_item.frame_last;

endmodule

FILE: sv/sld_checker.sv
// Port level checks of the deframer, bound to its top level.
module sld_checker
    import sld_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [BYTE_W-1:0]   o_frame_byte,
    input logic [ROLE_W-1:0]   o_byte_role,
    input logic [OFFSET_W-1:0] o_byte_offset,
    input logic                o_frame_last
);

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("Output valid dropped without a transaction.");

    a_payload_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_frame_byte) && $stable(o_byte_role)
            && $stable(o_byte_offset) && $stable(o_frame_last))
        else $error("Output payload changed while stalled.");

    a_last_is_trailer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_last |-> o_byte_role == ROLE_TRAILER)
        else $error("Frame end flagged on a byte that is not a trailer.");

    a_sync1_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_byte_role == ROLE_SYNC1 |-> o_byte_offset == '0 && !o_frame_last)
        else $error("Opening sync byte not at offset zero.");

    a_fixed_offsets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_byte_role == ROLE_SYNC2 || o_byte_role == ROLE_FCODE)
            |-> o_byte_offset == OFFSET_W'(o_byte_role))
        else $error("Header byte at the wrong offset.");

endmodule

bind sync_length_frame_deframer_unit sld_checker u_sld_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_frame_byte  (o_frame_byte),
    .o_byte_role   (o_byte_role),
    .o_byte_offset (o_byte_offset),
    .o_frame_last  (o_frame_last)
);
